// ===== design/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared widths, request codes and status types of the particle contact
// resolver.
// ----------------------------------------------------------------------------
package pcr_pkg;

   // Field widths of the request and response channels
   localparam int MODE_W  = 2;
   localparam int IDX_W   = 6;
   localparam int COMP_W  = 32;
   localparam int MASS_W  = 31;
   localparam int REST_W  = 17;

   // Divider operand widths
   localparam int DVD_W   = 64;
   localparam int DSR_W   = 33;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_LOAD_POS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_VEL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONTACT  = 2'd2;

   // Response kinds
   localparam logic KIND_VEL = 1'b0;
   localparam logic KIND_POS = 1'b1;

   // Divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== design/pcr_if.sv =====
// ----------------------------------------------------------------------------
// pcr_if
// Valid/ready channels for contact resolver requests and responses.
// ----------------------------------------------------------------------------
interface pcr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [pcr_pkg::MODE_W-1:0]    mode;
   logic        [pcr_pkg::IDX_W-1:0]     index_a;
   logic        [pcr_pkg::IDX_W-1:0]     index_b;
   logic                                 has_b;
   logic signed [pcr_pkg::COMP_W-1:0]    comp_x;
   logic signed [pcr_pkg::COMP_W-1:0]    comp_y;
   logic signed [pcr_pkg::COMP_W-1:0]    comp_z;
   logic        [pcr_pkg::MASS_W-1:0]    mass;
   logic        [pcr_pkg::REST_W-1:0]    restitution;
   logic signed [pcr_pkg::COMP_W-1:0]    depth;

   modport source (output valid, mode, index_a, index_b, has_b, comp_x, comp_y,
                   comp_z, mass, restitution, depth, input ready);
   modport sink   (input valid, mode, index_a, index_b, has_b, comp_x, comp_y,
                   comp_z, mass, restitution, depth, output ready);
endinterface

interface pcr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic        [pcr_pkg::IDX_W-1:0]     particle;
   logic                                 kind;
   logic signed [pcr_pkg::COMP_W-1:0]    out_x;
   logic signed [pcr_pkg::COMP_W-1:0]    out_y;
   logic signed [pcr_pkg::COMP_W-1:0]    out_z;
   logic                                 last;

   modport source (output valid, particle, kind, out_x, out_y, out_z, last,
                   input ready);
   modport sink   (input valid, particle, kind, out_x, out_y, out_z, last,
                   output ready);
endinterface

// ===== design/pcr_ram.sv =====
// ----------------------------------------------------------------------------
// pcr_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pcr_div.sv =====
// ----------------------------------------------------------------------------
// pcr_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pcr_pkg::DVD_W-1:0]    dividend,
   input  logic [pcr_pkg::DSR_W-1:0]    divisor,
   output logic [pcr_pkg::DVD_W-1:0]    quotient,
   output pcr_pkg::div_stat_type        stat
);

   localparam int CNT_W = $clog2(pcr_pkg::DVD_W);

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [pcr_pkg::DVD_W-1:0]   quo_ff;
   logic [pcr_pkg::DSR_W-1:0]   rem_ff;
   logic [pcr_pkg::DSR_W-1:0]   dsr_ff;
   logic [pcr_pkg::DSR_W:0]     rem_sh;
   logic [pcr_pkg::DSR_W:0]     diff;

   // Shift in the next dividend bit and trial-subtract
   assign rem_sh = {rem_ff, quo_ff[pcr_pkg::DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dsr_ff};

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(pcr_pkg::DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[pcr_pkg::DSR_W]) begin
            rem_ff <= diff[pcr_pkg::DSR_W-1:0];
            quo_ff <= {quo_ff[pcr_pkg::DVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[pcr_pkg::DSR_W-1:0];
            quo_ff <= {quo_ff[pcr_pkg::DVD_W-2:0], 1'b0};
         end
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== design/particle_contact_resolver_top.sv =====
// ----------------------------------------------------------------------------
// particle_contact_resolver_top
// Particle store with a sequenced contact resolver on one shared multiplier
// and one bit-serial divider.
// ----------------------------------------------------------------------------
// One request at a time. A velocity load, or a position load with a zero
// mass, is written in the accept cycle; a position load with a non-zero
// mass waits for the inverse-mass divide. A contact takes longer when
// impulse or push applies on a pair, and also waits on the response side:
// each of up to four impulse or push shares takes one 64-step pass of the
// bit-serial divider, and the dot product and updates run one component at
// a time through the shared multiplier, with a multiply state and then an
// accumulate state for each. Every store entry must be loaded before a
// contact reads it; there is no clearing pass after reset.
module particle_contact_resolver_top #(
   parameter int PARTICLES = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   pcr_req_if.sink          req_chan,
   pcr_rsp_if.source        rsp_chan
);

   localparam int AW     = $clog2(PARTICLES);
   localparam int CW     = pcr_pkg::COMP_W;
   localparam int PW     = 68;
   localparam int RECIP  = (4096 + PARTICLES - 1) / PARTICLES;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_INV_DIV  = 5'd1;
   localparam logic [4:0] ST_RD_A     = 5'd2;
   localparam logic [4:0] ST_LD_A     = 5'd3;
   localparam logic [4:0] ST_DOT_MUL  = 5'd4;
   localparam logic [4:0] ST_DOT_ACC  = 5'd5;
   localparam logic [4:0] ST_RD_B     = 5'd6;
   localparam logic [4:0] ST_LD_B     = 5'd7;
   localparam logic [4:0] ST_SEP      = 5'd8;
   localparam logic [4:0] ST_REST_MUL = 5'd9;
   localparam logic [4:0] ST_DELTA    = 5'd10;
   localparam logic [4:0] ST_SH_MUL   = 5'd11;
   localparam logic [4:0] ST_SH_DIV   = 5'd12;
   localparam logic [4:0] ST_SH_WAIT  = 5'd13;
   localparam logic [4:0] ST_UP_RD    = 5'd14;
   localparam logic [4:0] ST_UP_LD    = 5'd15;
   localparam logic [4:0] ST_UP_MUL   = 5'd16;
   localparam logic [4:0] ST_UP_ACC   = 5'd17;
   localparam logic [4:0] ST_UP_WR    = 5'd18;
   localparam logic [4:0] ST_EM_RD    = 5'd19;
   localparam logic [4:0] ST_EM_LD    = 5'd20;
   localparam logic [4:0] ST_EM_OUT   = 5'd21;

   localparam logic signed [PW-1:0] SAT_MAX = 68'sh7FFFFFFF;
   localparam logic signed [PW-1:0] SAT_MIN = -68'sh80000000;
   localparam logic signed [PW-1:0] D_CAP   = 68'sh100000000;
   localparam logic [pcr_pkg::DVD_W-1:0] INV_MAX = 64'h7FFFFFFF;

   // Wrap a request index into the store by reciprocal multiply, or pass it unchanged when PARTICLES is 64 or more
   function automatic logic [AW-1:0] wrap_idx(input logic [pcr_pkg::IDX_W-1:0] v);
      logic [18:0] q;
      logic [18:0] r;
      q = (19'(v) * 19'(RECIP)) >> 12;
      r = 19'(v) - q * 19'(PARTICLES);
      if (r >= 19'(PARTICLES)) begin
         r = r - 19'(PARTICLES);
      end
      if (PARTICLES >= 64) begin
         r = 19'(v);
      end
      return AW'(r);
   endfunction

   // Clamp to the signed 32-bit range
   function automatic logic signed [CW-1:0] sat32(input logic signed [PW-1:0] v);
      if (v > SAT_MAX) begin
         return SAT_MAX[CW-1:0];
      end else if (v < SAT_MIN) begin
         return SAT_MIN[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   logic [4:0]               state_ff;
   logic [4:0]               state_in;
   logic                     rsp_valid_ff;
   logic                     req_acc;

   logic [AW-1:0]            ia_ff;
   logic [AW-1:0]            ib_ff;
   logic                     hb_ff;
   logic signed [CW-1:0]     n_ff [3];
   logic signed [CW-1:0]     vec_ff [3];
   logic [pcr_pkg::REST_W-1:0] rest_ff;
   logic signed [CW-1:0]     depth_ff;
   logic [CW-1:0]            inva_ff;
   logic [CW-1:0]            invb_ff;
   logic signed [PW-1:0]     acc_ff;
   logic signed [CW-1:0]     sep_ff;
   logic [pcr_pkg::DSR_W-1:0] total_ff;
   logic                     imp_ok_ff;
   logic                     push_ok_ff;
   logic [32:0]              d_ff;
   logic [32:0]              share_ff [4];
   logic signed [PW-1:0]     prod_ff;
   logic                     side_ff;
   logic [1:0]               k_ff;
   logic [1:0]               j_ff;

   logic [pcr_pkg::IDX_W-1:0] rsp_particle_ff;
   logic                     rsp_kind_ff;
   logic signed [CW-1:0]     rsp_x_ff;
   logic signed [CW-1:0]     rsp_y_ff;
   logic signed [CW-1:0]     rsp_z_ff;
   logic                     rsp_last_ff;

   logic signed [33:0]       mul_a;
   logic signed [33:0]       mul_b;
   logic signed [PW-1:0]     mul_p;
   logic signed [PW-1:0]     prod_sh;
   logic signed [PW-1:0]     delta;
   logic                     sh_en;
   logic                     em_last;
   logic [AW-1:0]            up_idx;

   logic                     div_start;
   logic [pcr_pkg::DVD_W-1:0] div_dvd;
   logic [pcr_pkg::DSR_W-1:0] div_dsr;
   logic [pcr_pkg::DVD_W-1:0] div_quo;
   pcr_pkg::div_stat_type    div_stat;

   logic [AW-1:0]            ram_addr;
   logic                     vel_we;
   logic                     pos_we;
   logic                     im_we;
   logic [3*CW-1:0]          vel_wdata;
   logic [3*CW-1:0]          pos_wdata;
   logic [CW-1:0]            im_wdata;
   logic [3*CW-1:0]          vel_rdata;
   logic [3*CW-1:0]          pos_rdata;
   logic [CW-1:0]            im_rdata;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;

   // Shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DOT_MUL: begin
            mul_a = 34'(vec_ff[k_ff]);
            mul_b = 34'(n_ff[k_ff]);
         end
         ST_REST_MUL: begin
            mul_a = $signed({17'b0, rest_ff});
            mul_b = 34'(sep_ff);
         end
         ST_SH_MUL: begin
            mul_a = j_ff[1] ? 34'(depth_ff) : $signed({1'b0, d_ff});
            mul_b = $signed({2'b0, (j_ff[0] ? invb_ff : inva_ff)});
         end
         ST_UP_MUL: begin
            mul_a = $signed({1'b0, share_ff[j_ff]});
            mul_b = 34'(n_ff[k_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_sh = prod_ff >>> FRAC_BITS;
   assign delta   = ((-prod_ff) >>> FRAC_BITS) - PW'(sep_ff);
   assign sh_en   = (j_ff[1] ? push_ok_ff : imp_ok_ff) && (!j_ff[0] || hb_ff);
   assign em_last = (j_ff == 2'd3) || (!hb_ff && j_ff == 2'd1);
   assign up_idx  = j_ff[0] ? ib_ff : ia_ff;

   // Divider operands: inverse mass on load, share during a contact
   assign div_start = (req_acc && req_chan.mode == pcr_pkg::MODE_LOAD_POS &&
                       req_chan.mass != '0) || (state_ff == ST_SH_DIV);
   assign div_dvd   = (state_ff == ST_IDLE) ?
                      (pcr_pkg::DVD_W'(1) << (2 * FRAC_BITS)) : prod_ff[pcr_pkg::DVD_W-1:0];
   assign div_dsr   = (state_ff == ST_IDLE) ? {2'b0, req_chan.mass} : total_ff;

   pcr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // Store port selection
   always_comb begin
      vel_we    = 1'b0;
      pos_we    = 1'b0;
      im_we     = 1'b0;
      vel_wdata = {vec_ff[2], vec_ff[1], vec_ff[0]};
      pos_wdata = {vec_ff[2], vec_ff[1], vec_ff[0]};
      im_wdata  = '0;
      ram_addr  = ia_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_addr  = wrap_idx(req_chan.index_a);
            vel_wdata = {req_chan.comp_z, req_chan.comp_y, req_chan.comp_x};
            pos_wdata = {req_chan.comp_z, req_chan.comp_y, req_chan.comp_x};
            vel_we    = req_acc && req_chan.mode == pcr_pkg::MODE_LOAD_VEL;
            pos_we    = req_acc && req_chan.mode == pcr_pkg::MODE_LOAD_POS &&
                        req_chan.mass == '0;
            im_we     = pos_we;
         end
         ST_INV_DIV: begin
            pos_wdata = {n_ff[2], n_ff[1], n_ff[0]};
            pos_we    = div_stat.done;
            im_we     = div_stat.done;
            im_wdata  = (div_quo > INV_MAX) ? INV_MAX[CW-1:0] : div_quo[CW-1:0];
         end
         ST_RD_B:  ram_addr = ib_ff;
         ST_UP_RD: ram_addr = up_idx;
         ST_UP_WR: begin
            ram_addr = up_idx;
            vel_we   = !j_ff[1];
            pos_we   = j_ff[1];
         end
         ST_EM_RD: ram_addr = j_ff[1] ? ib_ff : ia_ff;
         default:  ram_addr = ia_ff;
      endcase
   end

   pcr_ram #(.WIDTH(3 * CW), .DEPTH(PARTICLES)) u_vel_ram (
      .clock (clock), .wr_en (vel_we), .addr (ram_addr),
      .wr_data (vel_wdata), .rd_data (vel_rdata)
   );

   pcr_ram #(.WIDTH(3 * CW), .DEPTH(PARTICLES)) u_pos_ram (
      .clock (clock), .wr_en (pos_we), .addr (ram_addr),
      .wr_data (pos_wdata), .rd_data (pos_rdata)
   );

   pcr_ram #(.WIDTH(CW), .DEPTH(PARTICLES)) u_im_ram (
      .clock (clock), .wr_en (im_we), .addr (ram_addr),
      .wr_data (im_wdata), .rd_data (im_rdata)
   );

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_chan.mode == pcr_pkg::MODE_CONTACT) begin
                  state_in = ST_RD_A;
               end else if (req_chan.mode == pcr_pkg::MODE_LOAD_POS &&
                            req_chan.mass != '0) begin
                  state_in = ST_INV_DIV;
               end
            end
         end
         ST_INV_DIV:  if (div_stat.done) state_in = ST_IDLE;
         ST_RD_A:     state_in = ST_LD_A;
         ST_LD_A:     state_in = ST_DOT_MUL;
         ST_DOT_MUL:  state_in = ST_DOT_ACC;
         ST_DOT_ACC: begin
            if (k_ff != 2'd2) begin
               state_in = ST_DOT_MUL;
            end else if (!side_ff && hb_ff) begin
               state_in = ST_RD_B;
            end else begin
               state_in = ST_SEP;
            end
         end
         ST_RD_B:     state_in = ST_LD_B;
         ST_LD_B:     state_in = ST_DOT_MUL;
         ST_SEP:      state_in = ST_REST_MUL;
         ST_REST_MUL: state_in = ST_DELTA;
         ST_DELTA:    state_in = ST_SH_MUL;
         ST_SH_MUL: begin
            if (sh_en) begin
               state_in = ST_SH_DIV;
            end else if (j_ff == 2'd3) begin
               state_in = ST_UP_RD;
            end
         end
         ST_SH_DIV:   state_in = ST_SH_WAIT;
         ST_SH_WAIT: begin
            if (div_stat.done) begin
               state_in = (j_ff == 2'd3) ? ST_UP_RD : ST_SH_MUL;
            end
         end
         ST_UP_RD: begin
            if (!j_ff[0] || hb_ff) begin
               state_in = ST_UP_LD;
            end else if (j_ff == 2'd3) begin
               state_in = ST_EM_RD;
            end
         end
         ST_UP_LD:    state_in = ST_UP_MUL;
         ST_UP_MUL:   state_in = ST_UP_ACC;
         ST_UP_ACC:   state_in = (k_ff == 2'd2) ? ST_UP_WR : ST_UP_MUL;
         ST_UP_WR:    state_in = (j_ff == 2'd3) ? ST_EM_RD : ST_UP_RD;
         ST_EM_RD:    state_in = ST_EM_LD;
         ST_EM_LD:    state_in = ST_EM_OUT;
         ST_EM_OUT: begin
            if (rsp_chan.ready) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_EM_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EM_LD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            ia_ff    <= wrap_idx(req_chan.index_a);
            ib_ff    <= wrap_idx(req_chan.index_b);
            hb_ff    <= req_chan.has_b;
            n_ff[0]  <= req_chan.comp_x;
            n_ff[1]  <= req_chan.comp_y;
            n_ff[2]  <= req_chan.comp_z;
            rest_ff  <= req_chan.restitution;
            depth_ff <= req_chan.depth;
         end
         ST_LD_A: begin
            inva_ff   <= im_rdata;
            invb_ff   <= '0;
            vec_ff[0] <= vel_rdata[CW-1:0];
            vec_ff[1] <= vel_rdata[2*CW-1:CW];
            vec_ff[2] <= vel_rdata[3*CW-1:2*CW];
            acc_ff    <= '0;
            side_ff   <= 1'b0;
            k_ff      <= '0;
         end
         ST_LD_B: begin
            invb_ff   <= im_rdata;
            vec_ff[0] <= vel_rdata[CW-1:0];
            vec_ff[1] <= vel_rdata[2*CW-1:CW];
            vec_ff[2] <= vel_rdata[3*CW-1:2*CW];
            side_ff   <= 1'b1;
            k_ff      <= '0;
         end
         ST_DOT_MUL:  prod_ff <= mul_p;
         // Accumulate a term of the separating speed, b side negated
         ST_DOT_ACC: begin
            acc_ff <= side_ff ? (acc_ff - prod_sh) : (acc_ff + prod_sh);
            k_ff   <= k_ff + 1'b1;
         end
         ST_SEP: begin
            sep_ff   <= sat32(acc_ff);
            total_ff <= {1'b0, inva_ff} + {1'b0, invb_ff};
         end
         ST_REST_MUL: begin
            prod_ff    <= mul_p;
            imp_ok_ff  <= (sep_ff <= 0) && (total_ff != '0);
            push_ok_ff <= (depth_ff > 0) && (total_ff != '0);
         end
         // Velocity change along the normal, capped at 2^32
         ST_DELTA: begin
            d_ff <= (delta > D_CAP) ? D_CAP[32:0] : delta[32:0];
            j_ff <= '0;
         end
         ST_SH_MUL: begin
            prod_ff <= mul_p;
            if (!sh_en) begin
               share_ff[j_ff] <= '0;
               j_ff           <= j_ff + 1'b1;
            end
         end
         ST_SH_WAIT: begin
            if (div_stat.done) begin
               share_ff[j_ff] <= div_quo[32:0];
               j_ff           <= j_ff + 1'b1;
            end
         end
         ST_UP_RD: begin
            if (j_ff[0] && !hb_ff) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         ST_UP_LD: begin
            vec_ff[0] <= j_ff[1] ? pos_rdata[CW-1:0] : vel_rdata[CW-1:0];
            vec_ff[1] <= j_ff[1] ? pos_rdata[2*CW-1:CW] : vel_rdata[2*CW-1:CW];
            vec_ff[2] <= j_ff[1] ? pos_rdata[3*CW-1:2*CW] : vel_rdata[3*CW-1:2*CW];
            k_ff      <= '0;
         end
         ST_UP_MUL:   prod_ff <= mul_p;
         // Add the share to a component, b side pushed the other way
         ST_UP_ACC: begin
            vec_ff[k_ff] <= sat32(PW'(vec_ff[k_ff]) + (j_ff[0] ? -prod_sh : prod_sh));
            k_ff         <= k_ff + 1'b1;
         end
         ST_UP_WR:    j_ff <= j_ff + 1'b1;
         ST_EM_LD: begin
            rsp_particle_ff <= pcr_pkg::IDX_W'(j_ff[1] ? ib_ff : ia_ff);
            rsp_kind_ff     <= j_ff[0] ? pcr_pkg::KIND_POS : pcr_pkg::KIND_VEL;
            rsp_x_ff        <= j_ff[0] ? pos_rdata[CW-1:0] : vel_rdata[CW-1:0];
            rsp_y_ff        <= j_ff[0] ? pos_rdata[2*CW-1:CW] : vel_rdata[2*CW-1:CW];
            rsp_z_ff        <= j_ff[0] ? pos_rdata[3*CW-1:2*CW] :
                                         vel_rdata[3*CW-1:2*CW];
            rsp_last_ff     <= em_last;
         end
         ST_EM_OUT: begin
            if (rsp_chan.ready) begin
               j_ff <= j_ff + 1'b1;
            end
         end
         default: begin
            prod_ff <= prod_ff;
         end
      endcase
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.particle = rsp_particle_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.out_x    = rsp_x_ff;
   assign rsp_chan.out_y    = rsp_y_ff;
   assign rsp_chan.out_z    = rsp_z_ff;
   assign rsp_chan.last     = rsp_last_ff;

`ifndef ASSERT_OFF
   // No response pending while a new request may be taken
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("response pending while request channel is ready");

   // The final response of a contact frees the request channel
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> req_chan.ready)
      else $error("request channel not ready after final response");

   // The divider is never left running while idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while idle");
`endif

endmodule
